[rtl/qrmc_pkg.sv]
package qrmc_pkg;

  // Frame geometry.
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;

  // Field widths.
  localparam int COORD_X_W = 10;
  localparam int COORD_Y_W = 9;
  localparam int CHAN_W    = 8;
  localparam int CNT_W     = 19;
  localparam int CFG_IDX_W = 3;

  // Frame bounds, one bit wider than the coordinates so that a full-range frame fits.
  localparam int XL_W = COORD_X_W + 1;
  localparam int YL_W = COORD_Y_W + 1;
  localparam logic [XL_W-1:0] X_LIMIT = XL_W'(FRAME_WIDTH);
  localparam logic [YL_W-1:0] Y_LIMIT = YL_W'(FRAME_HEIGHT);

  // The count saturates at the frame size, or at the largest count value.
  localparam int CNT_MAX_INT = (1 << CNT_W) - 1;
  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam logic [CNT_W-1:0] CNT_LIMIT =
    (FRAME_PIXELS > CNT_MAX_INT) ? CNT_W'(CNT_MAX_INT) : CNT_W'(FRAME_PIXELS);

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(500);

  // Arithmetic widths of the triangle test.
  // One product of a coordinate and a coordinate difference fits in PROD_W signed bits,
  // and a sum of four products in SUM_W.
  localparam int PROD_W = 21;
  localparam int SUM_W  = 23;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Corner register layout: x in the low bits, y above.
  typedef struct packed {
    logic [COORD_Y_W-1:0] y;
    logic [COORD_X_W-1:0] x;
  } corner_t;

  typedef struct packed {
    logic [COORD_X_W-1:0] pixel_x;
    logic [COORD_Y_W-1:0] pixel_y;
    logic [CHAN_W-1:0]    chan0;
    logic [CHAN_W-1:0]    chan1;
    logic [CHAN_W-1:0]    chan2;
    logic                 end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic             motion;
    logic [CNT_W-1:0] changed_count;
  } out_item_t;

  // Control that travels down the pipeline beside each item.
  typedef struct packed {
    logic valid;
    logic eof;
    logic cand;
  } ctrl_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_A  = 3'd0,
    REG_CORNER_B  = 3'd1,
    REG_CORNER_C  = 3'd2,
    REG_CORNER_D  = 3'd3,
    REG_THRESHOLD = 3'd4
  } cfg_reg_e;

  // Zero-extend a coordinate into the signed product width.
  function automatic prod_t widen_x(input logic [COORD_X_W-1:0] v);
    return prod_t'({{(PROD_W-COORD_X_W){1'b0}}, v});
  endfunction

  function automatic prod_t widen_y(input logic [COORD_Y_W-1:0] v);
    return prod_t'({{(PROD_W-COORD_Y_W){1'b0}}, v});
  endfunction

  // Signed product at full operand width; the true value always fits.
  function automatic prod_t mul(input prod_t a, input prod_t b);
    return a * b;
  endfunction

endpackage

[rtl/qrmc_tri.sv]
module qrmc_tri import qrmc_pkg::*; (
  input  logic                 clk,
  input  logic                 adv,
  input  corner_t              q0,
  input  corner_t              q1,
  input  corner_t              q2,
  input  logic [COORD_X_W-1:0] px,
  input  logic [COORD_Y_W-1:0] py,
  output logic                 hit
);

  prod_t x0, y0, x1, y1, x2, y2, pxw, pyw;

  prod_t sp0_r, sp1_r, sp2_r, sp3_r;
  prod_t tp0_r, tp1_r, tp2_r, tp3_r;
  prod_t ap0_r, ap1_r, ap2_r, ap3_r;

  sum_t s_r, t_r, a_r;
  sum_t sn, tn, an;
  logic inside_nxt, inside_r;

  // Operands in signed form.
  assign x0  = widen_x(q0.x);
  assign y0  = widen_y(q0.y);
  assign x1  = widen_x(q1.x);
  assign y1  = widen_y(q1.y);
  assign x2  = widen_x(q2.x);
  assign y2  = widen_y(q2.y);
  assign pxw = widen_x(px);
  assign pyw = widen_y(py);

  // First stage: every product of the two barycentric sums and the doubled area.
  always_ff @(posedge clk) begin
    if (adv) begin
      sp0_r <= mul(y0, x2);
      sp1_r <= mul(x0, y2);
      sp2_r <= mul(y2 - y0, pxw);
      sp3_r <= mul(x0 - x2, pyw);
      tp0_r <= mul(x0, y1);
      tp1_r <= mul(y0, x1);
      tp2_r <= mul(y0 - y1, pxw);
      tp3_r <= mul(x1 - x0, pyw);
      ap0_r <= mul(y1, x2);
      ap1_r <= mul(y0, x2 - x1);
      ap2_r <= mul(x0, y1 - y2);
      ap3_r <= mul(x1, y2);
    end
  end

  // Second stage: sum the products.
  always_ff @(posedge clk) begin
    if (adv) begin
      s_r <= SUM_W'(sp0_r) - SUM_W'(sp1_r) + SUM_W'(sp2_r) + SUM_W'(sp3_r);
      t_r <= SUM_W'(tp0_r) - SUM_W'(tp1_r) + SUM_W'(tp2_r) + SUM_W'(tp3_r);
      a_r <= SUM_W'(ap1_r) - SUM_W'(ap0_r) + SUM_W'(ap2_r) + SUM_W'(ap3_r);
    end
  end

  // Third stage: fold the orientation into the sums and test strict containment.
  // A zero area leaves no room for both sums to be positive and below it.
  always_comb begin
    if (a_r[SUM_W-1]) begin
      sn = -s_r;
      tn = -t_r;
      an = -a_r;
    end else begin
      sn = s_r;
      tn = t_r;
      an = a_r;
    end
    inside_nxt = (s_r[SUM_W-1] == t_r[SUM_W-1]) && (sn > 0) && (tn > 0) &&
                 ((sn + tn) < an);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= inside_nxt;
    end
  end

  assign hit = inside_r;

endmodule

[rtl/qrmc_count.sv]
module qrmc_count import qrmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_t            ctl,
  input  logic             hit,
  input  logic [CNT_W-1:0] threshold,
  input  logic             out_stall,
  output logic             adv,
  output logic             out_valid,
  output out_item_t        out_data
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic             counted;

  // The pipeline moves whenever the result register is empty or being taken.
  assign adv = !out_valid_r || !out_stall;

  // Saturating count including the current item.
  assign counted = ctl.cand && hit;
  assign cnt_inc = (counted && (cnt_r < CNT_LIMIT)) ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = ctl.valid && ctl.eof;
      if (ctl.valid) begin
        cnt_nxt = ctl.eof ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The frame report is loaded on the end-of-frame item.
  always_ff @(posedge clk) begin
    if (adv && ctl.valid && ctl.eof) begin
      out_data_r.changed_count <= cnt_inc;
      out_data_r.motion        <= (cnt_inc > threshold);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never passes its saturation limit.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_LIMIT)
    else $error("count above saturation limit");

  // An end-of-frame item yields a report and restarts the count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ctl.valid && ctl.eof) |=> (out_valid_r && (cnt_r == '0)))
    else $error("end of frame did not report and clear");

  // Any other item moves the count by at most one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ctl.valid && !ctl.eof) |=>
      ((cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CNT_W'(1))))
    else $error("count stepped by more than one");

  // A frozen pipeline leaves the count alone.
  assert property (@(posedge clk) disable iff (!rst_n) !adv |=> $stable(cnt_r))
    else $error("count changed while stalled");

endmodule

[rtl/quad_region_motion_counter.sv]
// Quadrilateral region motion counter.
// Pixels of a difference frame enter on the in_ channel (in_valid, in_stall, in_data), one
// item per clock while in_stall is low. A pixel is counted when any channel is nonzero,
// it lies in the frame, and it is strictly inside triangle A-B-D or triangle B-C-D of the
// corner registers. The item marked end_of_frame is counted first; then one result item
// leaves on the out_ channel with the frame's count and a motion flag (count above the
// threshold register), and the count restarts at zero. Other items give no result. The
// count saturates at the frame size.
// Registers are written on the cfg_ channel (index 0..4: corners A to D, threshold);
// cfg_ready is always high. Write them only while no item is in flight.
// An accepted item passes through the five register stages (input, products, sums,
// containment test, result) on its way to a result.
// Throughput: one item per cycle while out_stall is low.
// When the result register holds an item and out_stall is high, the whole pipeline
// freezes and in_stall is raised until the result is taken.
// Reset clears the count, the pipeline's control bits and the result valid flag, and sets
// the corners to zero and the threshold to 500.
module quad_region_motion_counter import qrmc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  corner_t          corner_a_r, corner_b_r, corner_c_r, corner_d_r;
  logic [CNT_W-1:0] threshold_r;

  ctrl_t                ctl0_r, ctl1_r, ctl2_r, ctl3_r;
  ctrl_t                ctl0_nxt;
  logic [COORD_X_W-1:0] px_r;
  logic [COORD_Y_W-1:0] py_r;

  logic adv;
  logic inside_abd, inside_bcd;
  logic nonzero, in_frame;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_a_r  <= '0;
      corner_b_r  <= '0;
      corner_c_r  <= '0;
      corner_d_r  <= '0;
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CORNER_A:  corner_a_r  <= cfg_data;
        REG_CORNER_B:  corner_b_r  <= cfg_data;
        REG_CORNER_C:  corner_c_r  <= cfg_data;
        REG_CORNER_D:  corner_d_r  <= cfg_data;
        REG_THRESHOLD: threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input qualification: a changed pixel that lies inside the frame.
  assign nonzero  = (in_data.chan0 != '0) || (in_data.chan1 != '0) || (in_data.chan2 != '0);
  assign in_frame = ({1'b0, in_data.pixel_x} < X_LIMIT) &&
                    ({1'b0, in_data.pixel_y} < Y_LIMIT);

  assign in_stall = !adv;

  always_comb begin
    ctl0_nxt.valid = in_valid;
    ctl0_nxt.eof   = in_data.end_of_frame;
    ctl0_nxt.cand  = nonzero && in_frame;
  end

  // Control pipeline, aligned with the input register and the three stages of the triangle test.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (adv) begin
      ctl0_r <= ctl0_nxt;
      ctl1_r <= ctl0_r;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  // Input register for the coordinates.
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= in_data.pixel_x;
      py_r <= in_data.pixel_y;
    end
  end

  // The two triangles that make up the region.
  qrmc_tri u_tri_abd (
    .clk (clk),
    .adv (adv),
    .q0  (corner_a_r),
    .q1  (corner_b_r),
    .q2  (corner_d_r),
    .px  (px_r),
    .py  (py_r),
    .hit (inside_abd)
  );

  qrmc_tri u_tri_bcd (
    .clk (clk),
    .adv (adv),
    .q0  (corner_b_r),
    .q1  (corner_c_r),
    .q2  (corner_d_r),
    .px  (px_r),
    .py  (py_r),
    .hit (inside_bcd)
  );

  // Frame count and result register.
  qrmc_count u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl3_r),
    .hit       (inside_abd || inside_bcd),
    .threshold (threshold_r),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
